FILE: src/etic_pkg.sv
// Package for the energy-triggered IQ capture block.
// Sizes, codes, state types and controller/datapath structs; no dependencies.
package etic_pkg;

   localparam int RECORD_DEPTH     = 65536;
   localparam int CALIB_BUFFERS    = 20;
   localparam int MAX_BUFFER_PAIRS = 65536;

   localparam int FUNC_W     = 2;
   localparam int SAMPLE_W   = 8;
   localparam int ADDR_W     = 16;
   localparam int EV_W       = 3;
   localparam int FACTOR_W   = 8;
   localparam int STORE_W    = 2 * SAMPLE_W;
   localparam int STORE_AW   = $clog2(RECORD_DEPTH);
   localparam int LEN_W      = $clog2(RECORD_DEPTH + 1);
   localparam int POS_W      = $clog2(MAX_BUFFER_PAIRS + 1);
   localparam int THR_W      = 21;
   localparam int POWER_W    = 17;
   localparam int SUM_W      = 34;
   localparam int MEAN_W     = 17;
   localparam int MED_W      = MEAN_W + 1;
   localparam int PROD_W     = THR_W + POS_W;
   localparam int THR_PROD_W = FACTOR_W + MED_W;
   localparam int THR_SHIFT  = 5;
   localparam int CNT_W      = $clog2(CALIB_BUFFERS + 1);
   localparam int MED_LO     = (CALIB_BUFFERS - 1) / 2;
   localparam int MED_HI     = CALIB_BUFFERS / 2;
   localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 8'd64;
   localparam logic [CSR_AW-1:0]   REG_FACTOR   = 3'd0;

   localparam logic [FUNC_W-1:0] FUNC_PAIR   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RESUME = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

   localparam logic [EV_W-1:0] EV_NONE         = 3'd0;
   localparam logic [EV_W-1:0] EV_CALIBRATED   = 3'd1;
   localparam logic [EV_W-1:0] EV_REC_START    = 3'd2;
   localparam logic [EV_W-1:0] EV_REC_EXTEND   = 3'd3;
   localparam logic [EV_W-1:0] EV_REC_DONE     = 3'd4;
   localparam logic [EV_W-1:0] EV_LISTENING    = 3'd5;

   typedef enum logic [2:0] {
      MODE_INIT,
      MODE_CAL,
      MODE_LISTEN,
      MODE_REC,
      MODE_PAUSE
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_EOB,
      ST_DIV,
      ST_INS,
      ST_THR,
      ST_THRW,
      ST_FIN
   } ctrl_state_type;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [SAMPLE_W-1:0] i_sample;
      logic [SAMPLE_W-1:0] q_sample;
      logic                last;
      logic [ADDR_W-1:0]   read_address;
   } req_payload_type;

   typedef struct packed {
      logic [EV_W-1:0]     event_res;
      logic [LEN_W-1:0]    recorded_pairs;
      logic [THR_W-1:0]    threshold_level;
      logic [SAMPLE_W-1:0] read_i;
      logic [SAMPLE_W-1:0] read_q;
   } rsp_payload_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic mul;
      logic div_start;
      logic insert;
      logic thr_mul;
      logic thr_set;
      logic eob;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_pair;
      logic calibrating;
      logic calib_last;
      logic div_busy;
   } dp_status_type;

endpackage

FILE: src/etic_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module etic_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: src/etic_div.sv
// Restoring divider, one quotient bit per cycle, for the calibration mean.
// Depends on etic_pkg.
module etic_div
   import etic_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  dividend,
   input  logic [POS_W-1:0]  divisor,
   output logic              busy,
   output logic [MEAN_W-1:0] quotient
);

   logic [POS_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [POS_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [POS_W:0]       trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = DIV_CNT_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where it fits
         if (trial >= {1'b0, den_ff}) begin
            rem_in = POS_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[POS_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff[MEAN_W-1:0];

endmodule

FILE: src/etic_ctrl.sv
// Sequencing state machine: steps the datapath through one request at a time.
// Depends on etic_pkg.
module etic_ctrl
   import etic_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = status.last_pair ? ST_MUL : ST_FIN;
         end
         ST_MUL: begin
            state_in = status.calibrating ? ST_DIV : ST_EOB;
         end
         ST_DIV: begin
            if (!status.div_busy) state_in = ST_INS;
         end
         ST_INS: begin
            state_in = status.calib_last ? ST_THR : ST_FIN;
         end
         ST_THR:  state_in = ST_THRW;
         ST_THRW: state_in = ST_FIN;
         ST_EOB:  state_in = ST_FIN;
         ST_FIN: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: cmd.accept = req_valid;
         ST_EXEC: cmd.exec = 1'b1;
         ST_MUL: begin
            cmd.mul       = 1'b1;
            cmd.div_start = status.calibrating;
         end
         ST_INS:  cmd.insert = !status.div_busy;
         ST_THR:  cmd.thr_mul = 1'b1;
         ST_THRW: cmd.thr_set = 1'b1;
         ST_EOB:  cmd.eob = 1'b1;
         ST_FIN: begin
            cmd.finish = out_free;
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/etic_dp.sv
// Datapath: power accumulation, recording store, calibration sort and threshold.
// Depends on etic_pkg, etic_div and etic_ram.
module etic_dp
   import etic_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   input  req_payload_type     req_data,
   input  logic [FACTOR_W-1:0] threshold_factor,
   output rsp_payload_type     rsp_data
);

   req_payload_type       req_ff, req_in;
   mode_type              mode_ff, mode_in, pair_mode;
   logic                  paused_ff, paused_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [MEAN_W-1:0]     sorted_ff [CALIB_BUFFERS];
   logic [MEAN_W-1:0]     sorted_in [CALIB_BUFFERS];
   logic [THR_W-1:0]      thr_ff, thr_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  ovf_ff, ovf_in;
   logic [LEN_W-1:0]      rl_ff, rl_in;
   logic [EV_W-1:0]       ev_ff, ev_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [THR_PROD_W-1:0] thr_prod_ff, thr_prod_in;
   logic                  hit_ff, hit_in;
   rsp_payload_type       rsp_ff, rsp_in;

   logic signed [9:0]     da, db;
   logic signed [19:0]    sqa, sqb;
   logic [POWER_W-1:0]    power;
   logic [LEN_W:0]        wr_full;
   logic [LEN_W:0]        ext_len;
   logic                  store_active, loud, good;
   logic [CALIB_BUFFERS-1:0] le;
   logic [MED_W-1:0]      twice_med;
   logic                  wr_en, rd_en;
   logic [STORE_W-1:0]    rd_data;
   logic                  div_busy;
   logic [MEAN_W-1:0]     mean;

   etic_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (pos_ff),
      .busy     (div_busy),
      .quotient (mean)
   );

   etic_ram #(
      .WIDTH (STORE_W),
      .DEPTH (RECORD_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_full[STORE_AW-1:0]),
      .wr_data ({req_ff.i_sample, req_ff.q_sample}),
      .rd_en   (rd_en),
      .rd_addr (req_ff.read_address[STORE_AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      da    = $signed({1'b0, req_ff.i_sample, 1'b0}) - 10'sd255;
      db    = $signed({1'b0, req_ff.q_sample, 1'b0}) - 10'sd255;
      sqa   = da * da;
      sqb   = db * db;
      power = {1'b0, sqa[15:0]} + {1'b0, sqb[15:0]};

      case (mode_ff)
         MODE_INIT:   pair_mode = MODE_CAL;
         MODE_CAL:    pair_mode = MODE_CAL;
         MODE_LISTEN: pair_mode = MODE_LISTEN;
         MODE_REC:    pair_mode = MODE_REC;
         MODE_PAUSE:  pair_mode = MODE_PAUSE;
         default:     pair_mode = MODE_CAL;
      endcase
      store_active = (pair_mode == MODE_LISTEN) || (pair_mode == MODE_REC) ||
                     ((pair_mode == MODE_PAUSE) && !paused_ff);
      wr_full = {1'b0, rl_ff} + (LEN_W+1)'(pos_ff);
      ext_len = {1'b0, rl_ff} + (LEN_W+1)'(pos_ff);

      loud = (pos_ff != '0) && ({{(PROD_W-SUM_W){1'b0}}, sum_ff} >= prod_ff);
      good = loud && !ovf_ff;

      for (int k = 0; k < CALIB_BUFFERS; k++) begin
         le[k] = (CNT_W'(k) < count_ff) && (sorted_ff[k] <= mean);
      end
      twice_med = {1'b0, sorted_ff[MED_LO]} + {1'b0, sorted_ff[MED_HI]};
   end

   always_comb begin
      req_in      = req_ff;
      mode_in     = mode_ff;
      paused_in   = paused_ff;
      count_in    = count_ff;
      thr_in      = thr_ff;
      sum_in      = sum_ff;
      pos_in      = pos_ff;
      ovf_in      = ovf_ff;
      rl_in       = rl_ff;
      ev_in       = ev_ff;
      prod_in     = prod_ff;
      thr_prod_in = thr_prod_ff;
      hit_in      = hit_ff;
      rsp_in      = rsp_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      for (int k = 0; k < CALIB_BUFFERS; k++) begin
         sorted_in[k] = sorted_ff[k];
      end

      if (cmd.accept) req_in = req_data;

      if (cmd.exec) begin
         ev_in = EV_NONE;
         case (req_ff.func)
            FUNC_PAIR: begin
               mode_in = pair_mode;
               if (pos_ff >= POS_W'(MAX_BUFFER_PAIRS)) begin
                  ovf_in = 1'b1;
               end else begin
                  if (store_active) begin
                     if (wr_full < (LEN_W+1)'(RECORD_DEPTH)) wr_en = 1'b1;
                     else ovf_in = 1'b1;
                  end else if (pair_mode == MODE_PAUSE) begin
                     ovf_in = 1'b1;
                  end
                  sum_in = sum_ff + SUM_W'(power);
                  pos_in = pos_ff + 1'b1;
               end
            end
            FUNC_RESUME: begin
               if ((mode_ff == MODE_PAUSE) && paused_ff) rl_in = '0;
               paused_in = 1'b0;
            end
            FUNC_READ: begin
               rd_en  = 1'b1;
               hit_in = ({1'b0, req_ff.read_address} < rl_ff);
            end
            default: ;
         endcase
      end

      if (cmd.mul) prod_in = PROD_W'(thr_ff) * PROD_W'(pos_ff);

      if (cmd.insert) begin
         // shift the larger entries up one place, drop the new mean in the gap
         for (int k = 0; k < CALIB_BUFFERS; k++) begin
            if (le[k]) sorted_in[k] = sorted_ff[k];
            else if (k == 0) sorted_in[k] = mean;
            else if (le[k-1]) sorted_in[k] = mean;
            else sorted_in[k] = sorted_ff[k-1];
         end
         count_in = count_ff + 1'b1;
         sum_in   = '0;
         pos_in   = '0;
         ovf_in   = 1'b0;
      end

      if (cmd.thr_mul) thr_prod_in = THR_PROD_W'(threshold_factor) * THR_PROD_W'(twice_med);

      if (cmd.thr_set) begin
         thr_in  = thr_prod_ff[THR_SHIFT +: THR_W];
         mode_in = MODE_LISTEN;
         ev_in   = EV_CALIBRATED;
      end

      if (cmd.eob) begin
         case (mode_ff)
            MODE_LISTEN: begin
               if (good) begin
                  rl_in = LEN_W'(pos_ff);
                  if (LEN_W'(pos_ff) >= LEN_W'(RECORD_DEPTH)) begin
                     mode_in = MODE_PAUSE; paused_in = 1'b1; ev_in = EV_REC_DONE;
                  end else begin
                     mode_in = MODE_REC; ev_in = EV_REC_START;
                  end
               end
            end
            MODE_REC: begin
               if (good) begin
                  rl_in = ext_len[LEN_W-1:0];
                  if (ext_len >= (LEN_W+1)'(RECORD_DEPTH)) begin
                     mode_in = MODE_PAUSE; paused_in = 1'b1; ev_in = EV_REC_DONE;
                  end else begin
                     ev_in = EV_REC_EXTEND;
                  end
               end else begin
                  mode_in = MODE_PAUSE; paused_in = 1'b1; ev_in = EV_REC_DONE;
               end
            end
            MODE_PAUSE: begin
               if (!paused_ff) begin
                  if (good) begin
                     rl_in = LEN_W'(pos_ff);
                     if (LEN_W'(pos_ff) >= LEN_W'(RECORD_DEPTH)) begin
                        paused_in = 1'b1; ev_in = EV_REC_DONE;
                     end else begin
                        mode_in = MODE_REC; ev_in = EV_REC_START;
                     end
                  end else begin
                     rl_in = '0; mode_in = MODE_LISTEN; ev_in = EV_LISTENING;
                  end
               end
            end
            default: ;
         endcase
         sum_in = '0;
         pos_in = '0;
         ovf_in = 1'b0;
      end

      if (cmd.finish) begin
         rsp_in.event_res       = ev_ff;
         rsp_in.recorded_pairs  = rl_ff;
         rsp_in.threshold_level = thr_ff;
         if ((req_ff.func == FUNC_READ) && hit_ff) begin
            rsp_in.read_i = rd_data[STORE_W-1 -: SAMPLE_W];
            rsp_in.read_q = rd_data[SAMPLE_W-1:0];
         end else begin
            rsp_in.read_i = '0;
            rsp_in.read_q = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_INIT;
         paused_ff <= 1'b0;
         count_ff  <= '0;
         thr_ff    <= '0;
         sum_ff    <= '0;
         pos_ff    <= '0;
         ovf_ff    <= 1'b0;
         rl_ff     <= '0;
      end else begin
         mode_ff   <= mode_in;
         paused_ff <= paused_in;
         count_ff  <= count_in;
         thr_ff    <= thr_in;
         sum_ff    <= sum_in;
         pos_ff    <= pos_in;
         ovf_ff    <= ovf_in;
         rl_ff     <= rl_in;
      end
      req_ff      <= req_in;
      ev_ff       <= ev_in;
      prod_ff     <= prod_in;
      thr_prod_ff <= thr_prod_in;
      hit_ff      <= hit_in;
      rsp_ff      <= rsp_in;
      for (int k = 0; k < CALIB_BUFFERS; k++) begin
         sorted_ff[k] <= sorted_in[k];
      end
   end

   assign status.last_pair   = (req_ff.func == FUNC_PAIR) && req_ff.last;
   assign status.calibrating = (mode_ff == MODE_CAL);
   assign status.calib_last  = (count_ff == CNT_W'(CALIB_BUFFERS - 1));
   assign status.div_busy    = div_busy;
   assign rsp_data           = rsp_ff;

endmodule

FILE: src/energy_triggered_iq_capture.sv
// Non-last pair, resume, read or no-op: accept, execute, then deliver the result.
// Last pair of a buffer: a multiply, then an end-of-buffer step or, during calibration, the
// divide by the one-bit-per-cycle divider that forms the buffer mean (34 steps) and an
// insert, plus threshold steps on the final buffer. One request at a time; a waiting
// result lets the next request in but holds its delivery. Reset: synchronous, active
// high; store has no clearing pass, reads only reach written entries.
module energy_triggered_iq_capture
   import etic_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  req_payload_type     req_data,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_payload_type     rsp_data,
   // register port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [CSR_DW-1:0]   pwdata,
   output logic [CSR_DW-1:0]   prdata,
   output logic                pready
);

   logic [FACTOR_W-1:0] factor_ff, factor_in;
   ctrl_cmd_type        cmd;
   dp_status_type       status;

   // threshold factor register; only latched into the threshold at calibration end
   always_comb begin
      factor_in = factor_ff;
      if (psel && penable && pwrite && (paddr == REG_FACTOR)) begin
         factor_in = pwdata[FACTOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_RESET;
      end else begin
         factor_ff <= factor_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == REG_FACTOR) ? CSR_DW'(factor_ff) : '0;

   // sequencer: accept, execute, end-of-buffer steps, deliver
   etic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // accumulation, store, calibration and detection decisions
   etic_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .threshold_factor (factor_ff),
      .rsp_data         (rsp_data)
   );

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.recorded_pairs <= LEN_W'(RECORD_DEPTH)))
      else $error("recorded length beyond store depth");

   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.event_res <= EV_LISTENING))
      else $error("undefined event code");

   a_start_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.event_res == EV_REC_START)) |-> (rsp_data.recorded_pairs != '0))
      else $error("recording started with no pairs");
`endif

endmodule
